// ----- rtl/vts_pkg.sv -----
`timescale 1ns / 1ps
package vts_pkg;

	typedef enum logic [7:0] {
		M_HDR     = 8'b0000_0001,
		M_SCALAR  = 8'b0000_0010,
		M_FLHDR   = 8'b0000_0100,
		M_ACOUNT  = 8'b0000_1000,
		M_ELEM    = 8'b0001_0000,
		M_FACOUNT = 8'b0010_0000,
		M_WIDTH   = 8'b0100_0000,
		M_PAYLOAD = 8'b1000_0000
	} mode_t;

	localparam logic [2:0] K_HDR     = 3'd0;
	localparam logic [2:0] K_SCALAR  = 3'd1;
	localparam logic [2:0] K_FLHDR   = 3'd2;
	localparam logic [2:0] K_ACOUNT  = 3'd3;
	localparam logic [2:0] K_ELEM    = 3'd4;
	localparam logic [2:0] K_WIDTH   = 3'd5;
	localparam logic [2:0] K_PAYLOAD = 3'd6;
	localparam logic [2:0] K_NONE    = 3'd7;

	localparam int L_HDR = 0;
	localparam int L_VAR = 1;
	localparam int L_FL  = 2;
	localparam int L_AC  = 3;
	localparam int L_PL  = 4;
	localparam int N_LISTS = 5;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] offset;
		logic [16:0] span;
		logic [2:0]  subtype;
		logic        cv;
		logic        ck;
		logic        fin;
	} rec_t;

	typedef struct packed {
		logic push;
		rec_t rec;
	} push_t;

endpackage

// ----- rtl/vts_in_if.sv -----
`timescale 1ns / 1ps
interface vts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, data_byte, last_byte, input ready);
	modport sink (input valid, data_byte, last_byte, output ready);
endinterface

// ----- rtl/vts_out_if.sv -----
`timescale 1ns / 1ps
interface vts_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  site_kind;
	logic [15:0] site_offset;
	logic [16:0] site_span;
	logic [2:0]  payload_subtype;
	logic        counted_as_varint;
	logic        counted_in_kind_list;
	logic        final_record;
	modport source (output valid, site_kind, site_offset, site_span, payload_subtype,
		counted_as_varint, counted_in_kind_list, final_record, input ready);
	modport sink (input valid, site_kind, site_offset, site_span, payload_subtype,
		counted_as_varint, counted_in_kind_list, final_record, output ready);
endinterface

// ----- rtl/vts_front.sv -----
`timescale 1ns / 1ps
module vts_front import vts_pkg::*; #(
	parameter int MAX_LEN      = 65536,
	parameter int SITE_CAP     = 256,
	parameter int VARINT_BYTES = 10
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   take,
	input  logic [7:0] data_byte,
	input  logic   last_byte,
	output push_t  push
);

	localparam int PW = $clog2(MAX_LEN + 1);
	localparam int CW = $clog2(MAX_LEN + 2);
	localparam int KW = $clog2(SITE_CAP + 1);
	localparam logic [PW-1:0] POS_MAX = PW'(MAX_LEN);
	localparam logic [63:0] SAT64 = 64'(MAX_LEN);
	localparam logic [63:0] CLIP64 = 64'(MAX_LEN + 1);
	localparam logic [CW-1:0] SATC = CW'(MAX_LEN);
	localparam logic [KW-1:0] CAP = KW'(SITE_CAP);

	mode_t           mode_q, mode_d;
	logic [PW-1:0]   pos_q, vstart_q, vstart_d, ps_q, ps_d;
	logic [3:0]      vb_q, vb_d, vb_n;
	logic [63:0]     val_q, val_n;
	logic [CW-1:0]   rem_q, rem_d, rem_dec, ec_q, ec_d;
	logic [2:0]      sub_q, sub_d;
	logic [KW-1:0]   cnt_q [N_LISTS];
	logic [N_LISTS-1:0] inc;
	logic            active, done, emit;
	logic [CW-1:0]   vclip, wclip, flclip;
	logic [2*CW-1:0] prod;
	logic [CW-1:0]   total;
	logic [31:0]     span32, pstart32;
	int              list;
	rec_t            rec;

	function automatic logic [CW-1:0] clip_sat(input logic [63:0] v);
		return (v > SAT64) ? SATC : CW'(v);
	endfunction

	function automatic logic [CW-1:0] clip_over(input logic [63:0] v);
		return (v > CLIP64) ? CW'(MAX_LEN + 1) : CW'(v);
	endfunction

	assign active  = pos_q < POS_MAX;
	assign rem_dec = rem_q - CW'(rem_q != '0);
	assign vb_n    = vb_q + 4'd1;
	assign val_n   = ((vb_q == 4'd0) ? 64'd0 : val_q) | (64'(data_byte[6:0]) << (7 * vb_q));
	assign done    = !data_byte[7] || (vb_n >= 4'(VARINT_BYTES));
	assign vclip   = clip_sat(val_n);
	assign flclip  = clip_sat(val_n >> 3);
	assign wclip   = clip_over(val_n >> 3);
	assign prod    = (2*CW)'(ec_q) * (2*CW)'(wclip);
	assign span32  = 32'(pos_q) - 32'(ps_q) + 32'd1;
	assign pstart32 = 32'(ps_q);

	always_comb begin
		// total length of a fixed array payload, saturated
		if (ec_q == '0 || wclip == '0) begin
			total = '0;
		end else if (prod > (2*CW)'(MAX_LEN)) begin
			total = SATC;
		end else begin
			total = CW'(prod);
		end
	end

	always_comb begin
		mode_d   = mode_q;
		vstart_d = vstart_q;
		vb_d     = vb_q;
		rem_d    = rem_q;
		ec_d     = ec_q;
		ps_d     = ps_q;
		sub_d    = sub_q;
		emit     = 1'b0;
		inc      = '0;
		list     = -1;
		rec      = '0;
		if (active) begin
			if (mode_q == M_PAYLOAD) begin
				rem_d = rem_dec;
				if (rem_dec == '0 || last_byte) begin
					emit        = 1'b1;
					inc[L_PL]   = cnt_q[L_PL] != CAP;
					rec.kind    = K_PAYLOAD;
					rec.offset  = pstart32[15:0];
					rec.span    = span32[16:0];
					rec.subtype = sub_q;
					rec.ck      = inc[L_PL];
					rem_d       = '0;
					mode_d      = M_HDR;
				end
			end else begin
				if (vb_q == 4'd0) begin
					vstart_d = pos_q;
				end
				vb_d = vb_n;
				unique case (mode_q)
					M_HDR:     begin rec.kind = K_HDR;    list = L_HDR; end
					M_SCALAR:  begin rec.kind = K_SCALAR; list = -1;    end
					M_FLHDR:   begin rec.kind = K_FLHDR;  list = L_FL;  end
					M_ACOUNT:  begin rec.kind = K_ACOUNT; list = L_AC;  end
					M_ELEM:    begin rec.kind = K_ELEM;   list = -1;    end
					M_FACOUNT: begin rec.kind = K_ACOUNT; list = L_AC;  end
					M_WIDTH:   begin rec.kind = K_WIDTH;  list = L_FL;  end
					default:   begin rec.kind = K_NONE;   list = -1;    end
				endcase
				if (done || last_byte) begin
					emit       = 1'b1;
					inc[L_VAR] = cnt_q[L_VAR] != CAP;
					for (int k = 0; k < N_LISTS; k++) begin
						if (k == list && k != L_VAR) begin
							inc[k] = cnt_q[k] != CAP;
						end
					end
					rec.cv     = inc[L_VAR];
					rec.ck     = (list >= 0) ? inc[list] : 1'b0;
					rec.offset = 16'(32'(vstart_d));
					rec.span   = 17'(vb_n);
					vb_d       = 4'd0;
				end
				if (done) begin
					// advance the item grammar on a completed varint
					unique case (mode_q)
						M_HDR: begin
							unique case (val_n[2:0])
								3'd0, 3'd1: mode_d = M_SCALAR;
								3'd2:       mode_d = M_FLHDR;
								3'd3, 3'd4: mode_d = M_ACOUNT;
								3'd5:       mode_d = M_FACOUNT;
								default:    mode_d = M_HDR;
							endcase
						end
						M_FLHDR: begin
							if (flclip == '0) begin
								mode_d = M_HDR;
							end else begin
								rem_d  = flclip;
								ps_d   = pos_q + PW'(1);
								sub_d  = val_n[2:0];
								mode_d = M_PAYLOAD;
							end
						end
						M_ACOUNT: begin
							if (val_n == 64'd0) begin
								mode_d = M_HDR;
							end else begin
								ec_d   = vclip;
								mode_d = M_ELEM;
							end
						end
						M_ELEM: begin
							if (ec_q <= CW'(1)) begin
								ec_d   = '0;
								mode_d = M_HDR;
							end else begin
								ec_d = ec_q - CW'(1);
							end
						end
						M_FACOUNT: begin
							ec_d   = clip_over(val_n);
							mode_d = M_WIDTH;
						end
						M_WIDTH: begin
							if (total == '0) begin
								mode_d = M_HDR;
							end else begin
								rem_d  = total;
								ps_d   = pos_q + PW'(1);
								sub_d  = val_n[2:0];
								mode_d = M_PAYLOAD;
							end
						end
						default: mode_d = M_HDR;
					endcase
				end
			end
		end
		if (last_byte && !emit) begin
			rec.kind   = K_NONE;
			rec.offset = 16'(32'(pos_q));
		end
		rec.fin   = last_byte;
		push.push = take && (emit || last_byte);
		push.rec  = rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_HDR;
			pos_q    <= '0;
			vstart_q <= '0;
			vb_q     <= '0;
			val_q    <= '0;
			rem_q    <= '0;
			ec_q     <= '0;
			ps_q     <= '0;
			sub_q    <= '0;
			for (int k = 0; k < N_LISTS; k++) cnt_q[k] <= '0;
		end else if (take) begin
			if (last_byte) begin
				// new buffer: drop all scan state
				mode_q   <= M_HDR;
				pos_q    <= '0;
				vstart_q <= '0;
				vb_q     <= '0;
				val_q    <= '0;
				rem_q    <= '0;
				ec_q     <= '0;
				ps_q     <= '0;
				sub_q    <= '0;
				for (int k = 0; k < N_LISTS; k++) cnt_q[k] <= '0;
			end else if (active) begin
				mode_q   <= mode_d;
				pos_q    <= pos_q + PW'(1);
				vstart_q <= vstart_d;
				vb_q     <= vb_d;
				if (mode_q != M_PAYLOAD) val_q <= val_n;
				rem_q    <= rem_d;
				ec_q     <= ec_d;
				ps_q     <= ps_d;
				sub_q    <= sub_d;
				for (int k = 0; k < N_LISTS; k++) begin
					if (inc[k]) cnt_q[k] <= cnt_q[k] + KW'(1);
				end
			end
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && last_byte |=> pos_q == '0 && mode_q == M_HDR)
		else $error("scan state not cleared after last byte");
	a_payload_rem: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_PAYLOAD |-> rem_q != '0)
		else $error("payload mode with nothing remaining");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_MAX)
		else $error("byte position beyond limit");
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[L_VAR] <= CAP && cnt_q[L_HDR] <= CAP && cnt_q[L_PL] <= CAP)
		else $error("list count above cap");

endmodule

// ----- rtl/vts_queue.sv -----
`timescale 1ns / 1ps
module vts_queue import vts_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  full,
	vts_out_if.source site_out
);

	localparam int DEPTH = 4;

	rec_t       mem_q [DEPTH];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       pop;
	rec_t       head;

	assign full  = cnt_q == 3'(DEPTH);
	assign pop   = site_out.valid && site_out.ready;
	assign head  = mem_q[rd_q];

	assign site_out.valid                = cnt_q != 3'd0;
	assign site_out.site_kind            = head.kind;
	assign site_out.site_offset          = head.offset;
	assign site_out.site_span            = head.span;
	assign site_out.payload_subtype      = head.subtype;
	assign site_out.counted_as_varint    = head.cv;
	assign site_out.counted_in_kind_list = head.ck;
	assign site_out.final_record         = head.fin;

	always_ff @(posedge clk) begin
		if (push.push) mem_q[wr_q] <= push.rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push.push) - 3'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push.push)
		else $error("push into full queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(DEPTH))
		else $error("queue count out of range");
	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> rd_q == $past(rd_q) + 2'd1)
		else $error("read pointer did not advance");

endmodule

// ----- rtl/varint_tlv_site_scanner.sv -----
`timescale 1ns / 1ps
// Channel   Role    Handshake     Payload
// byte_in   sink    valid/ready   data_byte, last_byte
// site_out  source  valid/ready   site_kind .. final_record
//
// One byte per cycle while the queue has room: the scanner updates its parse state on each accepted byte.
// At most one record per byte; records wait in a 4-entry queue.
// byte_in.ready drops only when the queue is full.
// Reset clears parse state, list counts and the queue; no clearing pass.
module varint_tlv_site_scanner import vts_pkg::*; #(
	parameter int MAX_LEN      = 65536,
	parameter int SITE_CAP     = 256,
	parameter int VARINT_BYTES = 10
) (
	input logic clk,
	input logic arst_n,
	vts_in_if.sink    byte_in,
	vts_out_if.source site_out
);

	push_t push;
	logic  full;
	logic  take;

	// accept a byte whenever the queue has room
	assign byte_in.ready = !full;
	assign take          = byte_in.valid && byte_in.ready;

	vts_front #(
		.MAX_LEN(MAX_LEN),
		.SITE_CAP(SITE_CAP),
		.VARINT_BYTES(VARINT_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.data_byte(byte_in.data_byte),
		.last_byte(byte_in.last_byte),
		.push(push)
	);

	// hold records until the sink takes them
	vts_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.site_out(site_out)
	);

endmodule
